/* rtl/clock_synced_polyphonic_lfo_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LFO block.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SYNCED_POLYPHONIC_LFO_MACROS_SVH
`define CLOCK_SYNCED_POLYPHONIC_LFO_MACROS_SVH

// same-cycle implication
`define CSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/csp_pkg.sv */
// ----------------------------------------------------------------------------
// csp_pkg
// Types, register codes and constant tables of the polyphonic LFO.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int CHANNELS_DEF        = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int FULL_LSB = 10240;
    localparam int LOW_THR  = 204;
    localparam int HIGH_THR = 4096;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLK,
        S_PITCH,
        S_EXP,
        S_SHIFT,
        S_DIV,
        S_UPD,
        S_ROM,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        REG_FREQ_PITCH  = 3'd0,
        REG_FM_AMOUNT   = 3'd1,
        REG_PULSE_WIDTH = 3'd2,
        REG_PWM_AMOUNT  = 3'd3,
        REG_UNIPOLAR    = 3'd4,
        REG_INVERT      = 3'd5,
        REG_SAMPLE_RATE = 3'd6
    } t_reg_idx;

    typedef logic [31:0] t_roots [13];

    function automatic longint unsigned isqrt64(input longint unsigned x_in);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        x = x_in;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // shift-subtract quotient, used for table construction only
    function automatic longint unsigned udiv64(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_roots build_roots();
        t_roots          t;
        longint unsigned r;
        r = 64'h8000_0000;
        t[0] = 32'(r);
        for (int i = 1; i <= 12; i++) begin
            r = isqrt64(r << 30);
            t[i] = 32'(r);
        end
        return t;
    endfunction

    // 2^(2^-j) in Q30
    localparam t_roots ROOTS = build_roots();

    // quarter-wave sine entry, Q30
    function automatic logic [30:0] sine_entry(input int i, input int bits);
        longint x;
        longint term;
        longint sum;
        x = longint'((64'd1686629713 * longint'(i)) >> bits);
        term = x;
        sum = x;
        for (int n = 1; n <= 7; n++) begin
            term = (((term * x) >>> 30) * x) >>> 30;
            term = $signed(udiv64($unsigned(term), 64'((2 * n) * (2 * n + 1))));
            if (n[0] == 1'b1) sum = sum - term;
            else sum = sum + term;
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        return 31'(sum);
    endfunction

endpackage

/* rtl/clock_synced_polyphonic_lfo.sv */
// ----------------------------------------------------------------------------
// clock_synced_polyphonic_lfo
// Polyphonic LFO synced to an external clock, one channel per transaction.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  in      | i_in_valid / o_in_ready + input fields     | sink
//  out     | o_out_valid / i_out_ready + waveforms      | source
//  cfg     | psel penable pwrite paddr pwdata prdata    | APB slave
//
//  Each transaction is dominated by 12 exp2 steps on the shared multiplier
//  and 76 steps of the bit-serial phase increment divider. o_in_ready is
//  high only while the sequencer is idle. The result waits in an output
//  register; a stalled output holds the sequencer in its last state.
//  Reset is synchronous; it clears control and channel state, not datapath.
// ----------------------------------------------------------------------------
`include "clock_synced_polyphonic_lfo_macros.svh"

module clock_synced_polyphonic_lfo #(
    parameter int CHANNELS        = csp_pkg::CHANNELS_DEF,
    parameter int SINE_TABLE_BITS = csp_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_channel,
    input  logic               i_frame_start,
    input  logic               i_clock_connected,
    input  logic signed [15:0] i_clock_volts,
    input  logic signed [15:0] i_reset_volts,
    input  logic signed [15:0] i_fm_volts,
    input  logic signed [15:0] i_pw_volts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_out_channel,
    output logic signed [15:0] o_sine_out,
    output logic signed [15:0] o_triangle_out,
    output logic signed [15:0] o_saw_out,
    output logic signed [15:0] o_square_out
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SINE_N = 1 << SINE_TABLE_BITS;
    localparam int IDX_W  = SINE_TABLE_BITS + 1;
    localparam int DQ_W   = 76;
    localparam int CNT_W  = 7;

    typedef logic [30:0] t_rom [SINE_N + 1];

    function automatic t_rom build_rom();
        t_rom t;
        for (int i = 0; i <= SINE_N; i++) t[i] = csp_pkg::sine_entry(i, SINE_TABLE_BITS);
        return t;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    function automatic logic [15:0] shape(input logic signed [16:0] v, input logic inv,
                                          input logic uni);
        logic signed [16:0] w;
        w = inv ? -v : v;
        if (uni) w = w + 17'sd10240;
        return w[15:0];
    endfunction

    // configuration
    logic signed [16:0] r_freq_pitch;
    logic signed [15:0] r_fm_amount;
    logic        [15:0] r_pulse_width;
    logic signed [15:0] r_pwm_amount;
    logic               r_unipolar;
    logic               r_invert;
    logic        [17:0] r_sample_rate;

    csp_pkg::t_reg_idx cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = csp_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_pitch  <= 17'sd4096;
            r_fm_amount   <= '0;
            r_pulse_width <= 16'd32768;
            r_pwm_amount  <= '0;
            r_unipolar    <= 1'b1;
            r_invert      <= 1'b0;
            r_sample_rate <= 18'd48000;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                csp_pkg::REG_FREQ_PITCH:  r_freq_pitch  <= pwdata[16:0];
                csp_pkg::REG_FM_AMOUNT:   r_fm_amount   <= pwdata[15:0];
                csp_pkg::REG_PULSE_WIDTH: r_pulse_width <= pwdata[15:0];
                csp_pkg::REG_PWM_AMOUNT:  r_pwm_amount  <= pwdata[15:0];
                csp_pkg::REG_UNIPOLAR:    r_unipolar    <= pwdata[0];
                csp_pkg::REG_INVERT:      r_invert      <= pwdata[0];
                csp_pkg::REG_SAMPLE_RATE: r_sample_rate <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            csp_pkg::REG_FREQ_PITCH:  prdata = {15'b0, r_freq_pitch};
            csp_pkg::REG_FM_AMOUNT:   prdata = {16'b0, r_fm_amount};
            csp_pkg::REG_PULSE_WIDTH: prdata = {16'b0, r_pulse_width};
            csp_pkg::REG_PWM_AMOUNT:  prdata = {16'b0, r_pwm_amount};
            csp_pkg::REG_UNIPOLAR:    prdata = {31'b0, r_unipolar};
            csp_pkg::REG_INVERT:      prdata = {31'b0, r_invert};
            csp_pkg::REG_SAMPLE_RATE: prdata = {14'b0, r_sample_rate};
            default:                  prdata = '0;
        endcase
    end

    // sequencer
    csp_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= csp_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            csp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = csp_pkg::S_CLK;
            end
            csp_pkg::S_CLK:   n_state = csp_pkg::S_PITCH;
            csp_pkg::S_PITCH: n_state = csp_pkg::S_EXP;
            csp_pkg::S_EXP:   if (r_cnt == CNT_W'(11)) n_state = csp_pkg::S_SHIFT;
            csp_pkg::S_SHIFT: n_state = csp_pkg::S_DIV;
            csp_pkg::S_DIV:   if (r_cnt == CNT_W'(DQ_W - 1)) n_state = csp_pkg::S_UPD;
            csp_pkg::S_UPD:   n_state = csp_pkg::S_ROM;
            csp_pkg::S_ROM:   n_state = csp_pkg::S_OUT;
            csp_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = csp_pkg::S_IDLE;
                end
            end
            default: n_state = csp_pkg::S_IDLE;
        endcase
    end

    // latched transaction
    logic [3:0]         r_ch;
    logic               r_fs, r_conn;
    logic signed [15:0] r_clock_v, r_reset_v, r_fm_v, r_pw_v;

    // state
    logic [31:0] r_phase [CHANNELS];
    logic        r_rtrig [CHANNELS];
    logic        r_ctrig;
    logic [31:0] r_sse;
    logic [31:0] r_period;

    // datapath
    logic signed [31:0] r_fm_prod, r_pw_prod;
    logic signed [5:0]  r_k;
    logic [11:0]        r_f;
    logic [30:0]        r_m;
    logic [22:0]        r_pw_u;
    logic signed [20:0] r_pw_q;
    logic [15:0]        r_pw;
    logic [DQ_W-1:0]    r_dq;
    logic [31:0]        r_rem;
    logic [31:0]        r_per;
    logic [31:0]        r_ph;
    logic [30:0]        r_sine_q;

    // clock handling
    logic [31:0] sse_inc;
    logic        c_rise, c_high;
    logic        cnt_ok;
    always_comb begin
        sse_inc = (r_sse == 32'hFFFF_FFFF) ? r_sse : r_sse + 32'd1;
        c_rise  = 1'b0;
        c_high  = r_ctrig;
        if (r_ctrig) begin
            if (r_clock_v <= 16'sd204) c_high = 1'b0;
        end else if (r_clock_v >= 16'sd4096) begin
            c_high = 1'b1;
            c_rise = 1'b1;
        end
        cnt_ok = ({10'b0, sse_inc} * 42'd1000 >= {24'b0, r_sample_rate})
              && ({10'b0, sse_inc} <= {24'b0, r_sample_rate} * 42'd1000);
    end

    // pitch
    logic signed [31:0] fm_sh;
    logic signed [19:0] pitch_sum, pitch_sat;
    always_comb begin
        fm_sh     = r_fm_prod >>> 13;
        pitch_sum = 20'(r_freq_pitch) + fm_sh[19:0];
        if (pitch_sum < -20'sd98304)     pitch_sat = -20'sd98304;
        else if (pitch_sum > 20'sd81920) pitch_sat = 20'sd81920;
        else                             pitch_sat = pitch_sum;
    end

    // shared multiplier step for exp2
    logic [62:0] exp_prod;
    assign exp_prod = {32'b0, r_m} * {31'b0, csp_pkg::ROOTS[r_cnt[3:0] + 4'd1]};

    // divider step
    logic [32:0] div_t;
    logic        div_ge;
    assign div_t  = {r_rem, r_dq[DQ_W-1]};
    assign div_ge = div_t >= {1'b0, r_per};

    logic [6:0] sh_amt;
    assign sh_amt = 7'(r_k) + 7'sd25;

    // pulse width reciprocal
    logic signed [31:0] pw_sh;
    logic [46:0]        pw_rec;
    logic signed [20:0] pw_sum;
    assign pw_sh  = r_pw_prod >>> 10;
    assign pw_rec = {24'b0, r_pw_u} * 47'd13421773;
    assign pw_sum = 21'($signed({1'b0, r_pulse_width})) + r_pw_q;

    // phase update
    logic        ch_ok;
    logic [51:0] dq_hi;
    logic [31:0] delta, ph_new;
    logic        r_rise, r_high;
    always_comb begin
        ch_ok  = {28'b0, r_ch} < 32'(CHANNELS);
        dq_hi  = r_dq[DQ_W-1:24];
        delta  = (dq_hi > 52'h8000_0000) ? 32'h8000_0000 : dq_hi[31:0];
        r_high = r_rtrig[r_ch[CH_W-1:0]];
        r_rise = 1'b0;
        if (r_rtrig[r_ch[CH_W-1:0]]) begin
            if (r_reset_v <= 16'sd204) r_high = 1'b0;
        end else if (r_reset_v >= 16'sd4096) begin
            r_high = 1'b1;
            r_rise = 1'b1;
        end
        ph_new = r_rise ? 32'd0 : r_phase[r_ch[CH_W-1:0]] + delta;
    end

    // sine table address
    logic [31:0]       ps;
    logic [IDX_W-1:0]  rom_a, rom_idx;
    always_comb begin
        ps      = r_unipolar ? r_ph - 32'h4000_0000 : r_ph;
        rom_a   = {1'b0, ps[29 -: SINE_TABLE_BITS]};
        rom_idx = ps[30] ? IDX_W'(SINE_N) - rom_a : rom_a;
    end

    // waveforms
    logic [44:0]        sine_prod;
    logic signed [16:0] sine_v, tri_v, saw_v, sq_v;
    logic [31:0]        pt, pz;
    logic [32:0]        tri_dist;
    logic [35:0]        dist10;
    logic signed [34:0] saw5;
    always_comb begin
        sine_prod = {14'b0, r_sine_q} * 45'd10240 + 45'h2000_0000;
        sine_v    = ps[31] ? -17'($signed({1'b0, sine_prod[44:30]}))
                           : 17'($signed({1'b0, sine_prod[44:30]}));
        pt        = r_unipolar ? r_ph : r_ph + 32'h4000_0000;
        tri_dist  = pt[31] ? 33'h1_0000_0000 - {1'b0, pt} : {1'b0, pt};
        dist10    = {3'b0, tri_dist} * 36'd10;
        tri_v     = $signed({1'b0, dist10[35:20]}) - 17'sd10240;
        pz        = r_unipolar ? r_ph ^ 32'h8000_0000 : r_ph;
        saw5      = 35'($signed(pz)) * 35'sd5;
        saw_v     = 17'(saw5 >>> 20);
        sq_v      = (r_ph < {r_pw, 16'b0}) ? 17'sd10240 : -17'sd10240;
    end

    always_ff @(posedge i_clk) begin
        r_sine_q <= SINE_ROM[rom_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_phase[c] <= '0;
                r_rtrig[c] <= 1'b1;
            end
            r_ctrig  <= 1'b1;
            r_sse    <= '0;
            r_period <= 32'd48000;
            r_cnt    <= '0;
        end else begin
            unique case (r_state)
                csp_pkg::S_IDLE: begin
                    r_ch      <= i_channel;
                    r_fs      <= i_frame_start;
                    r_conn    <= i_clock_connected;
                    r_clock_v <= i_clock_volts;
                    r_reset_v <= i_reset_volts;
                    r_fm_v    <= i_fm_volts;
                    r_pw_v    <= i_pw_volts;
                end
                csp_pkg::S_CLK: begin
                    if (r_fs) begin
                        if (r_conn) begin
                            r_ctrig <= c_high;
                            r_sse   <= c_rise ? 32'd0 : sse_inc;
                            if (c_rise && cnt_ok) r_period <= sse_inc;
                        end else begin
                            r_period <= {15'b0, r_sample_rate[17:1]};
                        end
                    end
                    r_fm_prod <= 32'(r_fm_v) * 32'(r_fm_amount);
                    r_pw_prod <= 32'(r_pw_v) * 32'(r_pwm_amount);
                end
                csp_pkg::S_PITCH: begin
                    r_k    <= pitch_sat[17:12];
                    r_f    <= pitch_sat[11:0];
                    r_m    <= 31'h4000_0000;
                    r_cnt  <= '0;
                    r_pw_u <= pw_sh[22:0] + 23'd5242880;
                end
                csp_pkg::S_EXP: begin
                    if (r_f[4'd11 - r_cnt[3:0]]) r_m <= exp_prod[60:30];
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                csp_pkg::S_SHIFT: begin
                    r_dq   <= {45'b0, r_m} << sh_amt;
                    r_rem  <= '0;
                    r_per  <= (r_period == 32'd0) ? 32'd1 : r_period;
                    r_cnt  <= '0;
                    r_pw_q <= pw_rec[46:26] - 21'd1048576;
                end
                csp_pkg::S_DIV: begin
                    r_rem <= div_ge ? 32'(div_t - {1'b0, r_per}) : div_t[31:0];
                    r_dq  <= {r_dq[DQ_W-2:0], div_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                csp_pkg::S_UPD: begin
                    if (ch_ok) begin
                        r_phase[r_ch[CH_W-1:0]] <= ph_new;
                        r_rtrig[r_ch[CH_W-1:0]] <= r_high;
                    end
                    r_ph <= ch_ok ? ph_new : 32'd0;
                    if (pw_sum < 21'sd655)        r_pw <= 16'd655;
                    else if (pw_sum > 21'sd64880) r_pw <= 16'd64880;
                    else                          r_pw <= pw_sum[15:0];
                end
                csp_pkg::S_ROM: ;
                csp_pkg::S_OUT: ;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out_channel  <= r_ch;
            o_sine_out     <= shape(sine_v, r_invert, r_unipolar);
            o_triangle_out <= shape(tri_v, r_invert, r_unipolar);
            o_saw_out      <= shape(saw_v, r_invert, r_unipolar);
            o_square_out   <= shape(sq_v, r_invert, r_unipolar);
        end
    end

    assign o_out_valid = r_out_valid;

    `CSP_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == csp_pkg::S_CLK, "accepted transaction did not start sequencer")
    `CSP_ASSERT_IMP(a_div_bound, i_clk, i_rst_n, r_state == csp_pkg::S_DIV,
        r_cnt < CNT_W'(DQ_W), "divider step count overran")
    `CSP_ASSERT_IMP(a_out_origin, i_clk, i_rst_n, $rose(o_out_valid),
        $past(r_state) == csp_pkg::S_OUT, "result appeared outside output state")
    `CSP_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        !out_load || r_state == csp_pkg::S_OUT, "stalled result overwritten")

endmodule
